// File: design/slsa_pkg.sv
// shared types, constants and controller/datapath interface structs for the scratchpad line store
package slsa_pkg;

    localparam int LINE_COUNT     = 1024;
    localparam int WORDS_PER_LINE = 8;
    localparam int LINE_W         = $clog2(LINE_COUNT);
    localparam int OFF_W          = $clog2(WORDS_PER_LINE);
    localparam int WADDR_W        = LINE_W + OFF_W;
    localparam int WORD_DEPTH     = LINE_COUNT * WORDS_PER_LINE;
    localparam int DATA_W         = 64;
    localparam int CFG_W          = 11;
    localparam int ST_W           = 3;
    localparam int PIN_W          = 8;
    localparam int META_W         = ST_W + PIN_W;
    localparam int OP_W           = 4;
    localparam int KIND_W         = 6;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(1024);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD       = 4'd0,
        OP_STORE      = 4'd1,
        OP_ATLOAD     = 4'd2,
        OP_ATSTORE    = 4'd3,
        OP_ADD        = 4'd4,
        OP_CAS        = 4'd5,
        OP_SWAP       = 4'd6,
        OP_REDUCE     = 4'd7,
        OP_ZERO       = 4'd8,
        OP_INVALIDATE = 4'd9,
        OP_PIN        = 4'd10,
        OP_UNPIN      = 4'd11,
        OP_STATUS     = 4'd12,
        OP_PREFETCH   = 4'd13
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_INVALID   = 3'd0,
        ST_SHARED    = 3'd1,
        ST_EXCLUSIVE = 3'd2,
        ST_MODIFIED  = 3'd3,
        ST_PINNED    = 3'd4
    } t_line_st;

    localparam logic [KIND_W-1:0] RK_SUM = 6'd0;
    localparam logic [KIND_W-1:0] RK_MIN = 6'd1;
    localparam logic [KIND_W-1:0] RK_MAX = 6'd2;
    localparam logic [KIND_W-1:0] RK_AND = 6'd3;
    localparam logic [KIND_W-1:0] RK_OR  = 6'd4;

    typedef struct packed {
        logic               accept;
        logic               commit;
        logic               clr_we;
        logic [WADDR_W-1:0] clr_addr;
        logic               sweep_we;
        logic [OFF_W-1:0]   sweep_off;
    } t_cmd;

    typedef struct packed {
        logic sweep;
    } t_sts;

endpackage

// File: design/slsa_ram.sv
// generic simple dual-port ram with registered read
module slsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/slsa_ctrl.sv
// controller state machine: reset clearing pass, accept, commit and line sweep sequencing
module slsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  slsa_pkg::t_sts i_sts,
    output slsa_pkg::t_cmd o_cmd
);
    import slsa_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } t_fsm;

    t_fsm               r_state;
    t_fsm               n_state;
    logic [WADDR_W-1:0] r_cnt;
    logic [WADDR_W-1:0] n_cnt;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we   = 1'b1;
                o_cmd.clr_addr = r_cnt;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == WADDR_W'(WORD_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_cnt        = '0;
                    n_state      = i_sts.sweep ? S_SWEEP : S_IDLE;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_we  = 1'b1;
                o_cmd.sweep_off = r_cnt[OFF_W-1:0];
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt[OFF_W-1:0] == OFF_W'(WORDS_PER_LINE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted transaction did not enter execution");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (o_in_stall && !o_cmd.commit && !r_out_valid))
        else $error("activity during clearing pass");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_cnt[OFF_W-1:0] == OFF_W'(WORDS_PER_LINE - 1))
        |=> (r_state == S_IDLE))
        else $error("line sweep overran");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit) |=> (r_out_valid && r_state != S_EXEC))
        else $error("commit did not present a result");
`endif

endmodule

// File: design/slsa_dp.sv
// datapath: input capture, word and line metadata rams, operation logic and result register
module slsa_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  slsa_pkg::t_cmd               i_cmd,
    output slsa_pkg::t_sts               o_sts,
    input  logic                         i_cfg_we,
    input  logic [slsa_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [slsa_pkg::OP_W-1:0]    i_op,
    input  logic [slsa_pkg::LINE_W-1:0]  i_line_index,
    input  logic [slsa_pkg::OFF_W-1:0]   i_word_offset,
    input  logic [slsa_pkg::DATA_W-1:0]  i_operand,
    input  logic [slsa_pkg::DATA_W-1:0]  i_expected,
    input  logic [slsa_pkg::KIND_W-1:0]  i_reduce_kind,
    output logic [slsa_pkg::DATA_W-1:0]  o_read_data,
    output logic [slsa_pkg::ST_W-1:0]    o_line_status,
    output logic                         o_error
);
    import slsa_pkg::*;

    logic [CFG_W-1:0]  r_active;
    t_op               r_op;
    logic [LINE_W-1:0] r_line;
    logic [OFF_W-1:0]  r_off;
    logic [DATA_W-1:0] r_operand;
    logic [DATA_W-1:0] r_expected;
    logic [KIND_W-1:0] r_kind;
    logic [DATA_W-1:0] r_read_data;
    logic [ST_W-1:0]   r_line_status;
    logic              r_error;

    logic [DATA_W-1:0]  old_word;
    logic [META_W-1:0]  meta_q;
    t_line_st           cur_st;
    logic [PIN_W-1:0]   cur_pin;
    t_line_st           n_st;
    logic [PIN_W-1:0]   n_pin;
    logic [DATA_W-1:0]  n_word;
    logic [DATA_W-1:0]  res_data;
    logic [ST_W-1:0]    res_status;
    logic               res_error;
    logic               wr_word;
    logic               wr_meta;
    logic               sweep;
    logic               range_err;

    logic               w_we;
    logic [WADDR_W-1:0] w_waddr;
    logic [DATA_W-1:0]  w_wdata;
    logic               m_we;
    logic [LINE_W-1:0]  m_waddr;
    logic [META_W-1:0]  m_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= t_op'(i_op);
            r_line     <= i_line_index;
            r_off      <= i_word_offset;
            r_operand  <= i_operand;
            r_expected <= i_expected;
            r_kind     <= i_reduce_kind;
        end
        if (i_cmd.commit) begin
            r_read_data   <= res_data;
            r_line_status <= res_status;
            r_error       <= res_error;
        end
    end

    assign cur_st    = t_line_st'(meta_q[META_W-1:PIN_W]);
    assign cur_pin   = meta_q[PIN_W-1:0];
    assign range_err = ({1'b0, r_line} >= r_active) || (32'(r_line) >= LINE_COUNT);

    always_comb begin
        n_st       = cur_st;
        n_pin      = cur_pin;
        n_word     = old_word;
        res_data   = '0;
        res_error  = 1'b0;
        wr_word    = 1'b0;
        wr_meta    = 1'b0;
        sweep      = 1'b0;
        res_status = '0;
        if (range_err) begin
            res_error = (r_op <= OP_PREFETCH);
        end else begin
            res_status = cur_st;
            wr_meta    = 1'b1;
            unique case (r_op)
                OP_LOAD, OP_PREFETCH: begin
                    if (cur_st == ST_INVALID) begin
                        n_st = ST_SHARED;
                    end
                    if (r_op == OP_LOAD) begin
                        res_data = old_word;
                    end
                end
                OP_STORE, OP_ATSTORE: begin
                    n_word  = r_operand;
                    n_st    = ST_MODIFIED;
                    wr_word = 1'b1;
                end
                OP_ATLOAD: begin
                    res_data = old_word;
                end
                OP_ADD: begin
                    n_word   = old_word + r_operand;
                    n_st     = ST_MODIFIED;
                    wr_word  = 1'b1;
                    res_data = old_word;
                end
                OP_CAS: begin
                    if (old_word == r_expected) begin
                        n_word  = r_operand;
                        n_st    = ST_MODIFIED;
                        wr_word = 1'b1;
                    end
                    res_data = old_word;
                end
                OP_SWAP: begin
                    n_word   = r_operand;
                    n_st     = ST_MODIFIED;
                    wr_word  = 1'b1;
                    res_data = old_word;
                end
                OP_REDUCE: begin
                    wr_word  = 1'b1;
                    n_st     = ST_MODIFIED;
                    res_data = old_word;
                    unique case (r_kind)
                        RK_SUM: n_word = old_word + r_operand;
                        RK_MIN: n_word = (old_word < r_operand) ? old_word : r_operand;
                        RK_MAX: n_word = (old_word > r_operand) ? old_word : r_operand;
                        RK_AND: n_word = old_word & r_operand;
                        RK_OR:  n_word = old_word | r_operand;
                        default: begin
                            wr_word   = 1'b0;
                            wr_meta   = 1'b0;
                            n_st      = cur_st;
                            res_data  = '0;
                            res_error = 1'b1;
                        end
                    endcase
                end
                OP_ZERO: begin
                    n_st  = ST_EXCLUSIVE;
                    sweep = 1'b1;
                end
                OP_INVALIDATE: begin
                    n_st  = ST_INVALID;
                    n_pin = '0;
                    sweep = 1'b1;
                end
                OP_PIN: begin
                    n_st  = ST_PINNED;
                    n_pin = cur_pin + 1'b1;
                end
                OP_UNPIN: begin
                    if (cur_st == ST_INVALID) begin
                        n_st = ST_PINNED;
                    end
                    if (cur_pin != '0) begin
                        n_pin = cur_pin - 1'b1;
                        if (cur_pin == PIN_W'(1)) begin
                            n_st = ST_EXCLUSIVE;
                        end
                    end
                end
                OP_STATUS: begin
                    wr_meta = 1'b0;
                end
                default: begin
                    wr_meta    = 1'b0;
                    res_status = '0;
                end
            endcase
            if (wr_meta) begin
                res_status = n_st;
            end
        end
    end

    assign o_sts.sweep = sweep;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_line, r_off};
        w_wdata = n_word;
        priority if (i_cmd.clr_we) begin
            w_we    = 1'b1;
            w_waddr = i_cmd.clr_addr;
            w_wdata = '0;
        end else if (i_cmd.sweep_we) begin
            w_we    = 1'b1;
            w_waddr = {r_line, i_cmd.sweep_off};
            w_wdata = '0;
        end else begin
            w_we = i_cmd.commit && wr_word;
        end
    end

    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_line;
        m_wdata = {n_st, n_pin};
        priority if (i_cmd.clr_we) begin
            m_we    = 1'b1;
            m_waddr = i_cmd.clr_addr[WADDR_W-1:OFF_W];
            m_wdata = '0;
        end else begin
            m_we = i_cmd.commit && wr_meta;
        end
    end

    slsa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WORD_DEPTH)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr ({i_line_index, i_word_offset}),
        .o_rdata (old_word)
    );

    slsa_ram #(
        .WIDTH (META_W),
        .DEPTH (LINE_COUNT)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (i_line_index),
        .o_rdata (meta_q)
    );

    assign o_read_data   = r_read_data;
    assign o_line_status = r_line_status;
    assign o_error       = r_error;

endmodule

// File: design/scratchpad_line_store_atomics.sv
// top level of the scratchpad line store with atomic operations
// a transaction is accepted, then its result is registered at commit, which waits while a previous result is stalled
// a new transaction is taken only once the last one has committed, as the word ram is read (registered) then written
// zero and invalidate line add a sweep that writes zero to each of the line's 8 words before input is taken again
// reset: synchronous active low; a clearing pass over all 8192 word ram entries (one entry a cycle)
// follows, stalling input while configuration writes are still taken
module scratchpad_line_store_atomics (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [slsa_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [slsa_pkg::OP_W-1:0]    i_op,
    input  logic [slsa_pkg::LINE_W-1:0]  i_line_index,
    input  logic [slsa_pkg::OFF_W-1:0]   i_word_offset,
    input  logic [slsa_pkg::DATA_W-1:0]  i_operand,
    input  logic [slsa_pkg::DATA_W-1:0]  i_expected,
    input  logic [slsa_pkg::KIND_W-1:0]  i_reduce_kind,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [slsa_pkg::DATA_W-1:0]  o_read_data,
    output logic [slsa_pkg::ST_W-1:0]    o_line_status,
    output logic                         o_error
);
    import slsa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    slsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    slsa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_line_index  (i_line_index),
        .i_word_offset (i_word_offset),
        .i_operand     (i_operand),
        .i_expected    (i_expected),
        .i_reduce_kind (i_reduce_kind),
        .o_read_data   (o_read_data),
        .o_line_status (o_line_status),
        .o_error       (o_error)
    );

endmodule
